// ===== sv/qpq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package qpq_pkg;

    localparam int DEPTH = 16;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int OCC_W = 5;

    localparam logic CMD_ENQ = 1'b0;
    localparam logic CMD_DEQ = 1'b1;

    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW = 2'd2;

    localparam logic [1:0] PRI_NONE = 2'd0;
    localparam logic [1:0] PRI_HIGH = 2'd1;

    typedef struct packed {
        logic       cmd;
        logic [1:0] priority_req;
        logic [6:0] age;
        logic [7:0] tag;
    } in_item_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [1:0]       out_priority;
        logic [6:0]       out_age;
        logic [7:0]       out_tag;
        logic [OCC_W-1:0] occupancy;
    } out_item_t;

    typedef struct packed {
        logic [1:0] pri;
        logic [6:0] age;
        logic [7:0] tag;
    } entry_t;

    typedef struct packed {
        logic capture;
        logic execute;
    } dp_cmd_t;

    typedef enum logic {
        FSM_IDLE,
        FSM_EXEC
    } fsm_state_t;

endpackage

`default_nettype wire

// ===== sv/three_level_priority_queue_unit.sv =====
// Three-level priority queue of up to 16 records (priority 1 high .. 3 low,
// 7-bit age, 8-bit tag). Records of equal priority leave in arrival order.
//
// Input channel in_valid/in_ready/in_item: cmd 0 enqueues, cmd 1 dequeues
// the front record. Every item yields exactly one result item on
// out_valid/out_ready/out_item: status (done, overflow, underflow), the
// dequeued record (zeros otherwise) and the occupancy after the operation.
//
// Each item has a capture step and then an update step, in which all 16
// cells compare against the new priority and shift in parallel and the
// result register is written. The next item is taken while a result waits
// in the output register; a stalled receiver holds the update until that
// register drains, and no item is lost. No new item is taken before the
// update of the last one.
//
// Reset clears the occupancy and the handshake state; record cells are not
// cleared and are never read before being written.
`timescale 1ns / 1ps
`default_nettype none

module three_level_priority_queue_unit
    import qpq_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire in_item_t  in_item,
    output logic           out_valid,
    input  wire logic      out_ready,
    output out_item_t      out_item
);

    dp_cmd_t dp_cmd;

    qpq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .dp_cmd    (dp_cmd)
    );

    qpq_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .dp_cmd   (dp_cmd),
        .in_item  (in_item),
        .out_item (out_item)
    );

endmodule

`default_nettype wire

// ===== sv/qpq_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module qpq_ctrl
    import qpq_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_ready,
    output logic         out_valid,
    input  wire logic    out_ready,
    output dp_cmd_t      dp_cmd
);

    fsm_state_t state_reg;
    fsm_state_t state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= FSM_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        in_ready        = 1'b0;
        dp_cmd.capture  = 1'b0;
        dp_cmd.execute  = 1'b0;
        out_valid_next  = out_valid_reg && !out_ready;
        unique case (state_reg)
            FSM_IDLE:
            begin
                in_ready       = 1'b1;
                dp_cmd.capture = in_valid;
                if (in_valid)
                begin
                    state_next = FSM_EXEC;
                end
            end
            FSM_EXEC:
            begin
                // result slot free or draining this cycle
                if (!out_valid_reg || out_ready)
                begin
                    dp_cmd.execute = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = FSM_IDLE;
                end
            end
            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// ===== sv/qpq_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module qpq_datapath
    import qpq_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire dp_cmd_t  dp_cmd,
    input  wire in_item_t in_item,
    output out_item_t     out_item
);

    in_item_t           op_reg;
    entry_t             cells_reg [DEPTH];
    entry_t             cells_next [DEPTH];
    entry_t             cells_up [DEPTH];
    entry_t             cells_dn [DEPTH];
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    out_item_t          res_reg;
    out_item_t          res_next;
    logic [DEPTH-1:0]   stay;
    logic [DEPTH-1:0]   stay_prev;
    logic [1:0]         pri_eff;
    entry_t             new_entry;
    logic               full;
    logic               empty;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign empty     = (count_reg == '0);
    assign pri_eff   = (op_reg.priority_req == PRI_NONE) ? PRI_HIGH : op_reg.priority_req;
    assign new_entry = '{pri: pri_eff, age: op_reg.age, tag: op_reg.tag};

    // stored entries of equal or more urgent priority keep their cell
    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            assign stay[g] = (CNT_W'(g) < count_reg) && (cells_reg[g].pri <= pri_eff);
            if (g == 0)
            begin : g_first
                assign cells_up[g]  = new_entry;
                assign stay_prev[g] = 1'b1;
            end
            else
            begin : g_rest
                assign cells_up[g]  = cells_reg[g-1];
                assign stay_prev[g] = stay[g-1];
            end
            if (g == DEPTH - 1)
            begin : g_last
                assign cells_dn[g] = cells_reg[g];
            end
            else
            begin : g_mid
                assign cells_dn[g] = cells_reg[g+1];
            end
        end
    endgenerate

    always_comb
    begin
        cells_next = cells_reg;
        count_next = count_reg;
        res_next   = '0;
        unique case (op_reg.cmd)
            CMD_ENQ:
            begin
                if (full)
                begin
                    res_next.status = ST_OVERFLOW;
                end
                else
                begin
                    for (int i = 0; i < DEPTH; i++)
                    begin
                        if (stay[i])
                        begin
                            cells_next[i] = cells_reg[i];
                        end
                        else if (stay_prev[i])
                        begin
                            cells_next[i] = new_entry;
                        end
                        else
                        begin
                            cells_next[i] = cells_up[i];
                        end
                    end
                    count_next      = count_reg + CNT_W'(1);
                    res_next.status = ST_DONE;
                end
            end
            CMD_DEQ:
            begin
                if (empty)
                begin
                    res_next.status = ST_UNDERFLOW;
                end
                else
                begin
                    cells_next            = cells_dn;
                    count_next            = count_reg - CNT_W'(1);
                    res_next.status       = ST_DONE;
                    res_next.out_priority = cells_reg[0].pri;
                    res_next.out_age      = cells_reg[0].age;
                    res_next.out_tag      = cells_reg[0].tag;
                end
            end
            default:
            begin
                res_next.status = ST_DONE;
            end
        endcase
        res_next.occupancy = OCC_W'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (dp_cmd.execute)
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (dp_cmd.capture)
        begin
            op_reg <= in_item;
        end
        if (dp_cmd.execute)
        begin
            cells_reg <= cells_next;
            res_reg   <= res_next;
        end
    end

    assign out_item = res_reg;

endmodule

`default_nettype wire

// ===== sv/qpq_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module qpq_assertions
    import qpq_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      in_valid,
    input wire logic      in_ready,
    input wire logic      out_valid,
    input wire logic      out_ready,
    input wire out_item_t out_item
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_item))
        else $error("result item changed while stalled");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second item taken while one is in flight");

    a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.status == ST_OVERFLOW |->
            out_item.occupancy == OCC_W'(DEPTH) && out_item.out_priority == PRI_NONE)
        else $error("overflow reported with free space");

    a_underflow_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.status == ST_UNDERFLOW |->
            out_item.occupancy == '0 && out_item.out_priority == PRI_NONE)
        else $error("underflow reported on nonempty queue");

    a_deq_pri: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.status == ST_DONE && out_item.out_priority != PRI_NONE |->
            out_item.occupancy != OCC_W'(DEPTH))
        else $error("dequeue left the queue full");

endmodule

bind three_level_priority_queue_unit qpq_assertions u_qpq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
);

`default_nettype wire
